>>> design/mts_pkg.sv
`timescale 1ns / 1ps

package mts_pkg;

    // widths fixed by the item fields
    localparam int VALUE_W = 32;
    localparam int ENTRY_W = 34;

    // operation codes
    localparam logic [1:0] FUNC_PUSH    = 2'd0;
    localparam logic [1:0] FUNC_POP     = 2'd1;
    localparam logic [1:0] FUNC_MIN_RD  = 2'd2;

    // result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]                func;
        logic signed [VALUE_W-1:0] push_value;
    } req_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] result_value;
        logic [1:0]                status;
    } rsp_t;

    // outcome of the top-of-stack decode on a pop
    typedef struct packed {
        logic                      take_min;
        logic signed [VALUE_W-1:0] value;
        logic signed [VALUE_W-1:0] restored_min;
    } pop_dec_t;

endpackage

>>> design/mts_entry_ram.sv
`timescale 1ns / 1ps

module mts_entry_ram
    import mts_pkg::*;
#(
    parameter int DEPTH  = 256,
    parameter int ADDR_W = 8
) (
    input  logic                      clk,
    input  logic                      wr_en,
    input  logic [ADDR_W-1:0]         wr_addr,
    input  logic signed [ENTRY_W-1:0] wr_data,
    input  logic                      rd_en,
    input  logic [ADDR_W-1:0]         rd_addr,
    output logic signed [ENTRY_W-1:0] rd_data
);

    logic signed [ENTRY_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> design/mts_min_unit.sv
`timescale 1ns / 1ps

module mts_min_unit
    import mts_pkg::*;
(
    input  logic signed [VALUE_W-1:0] push_value,
    input  logic signed [VALUE_W-1:0] cur_min,
    input  logic                      stack_empty,
    input  logic signed [ENTRY_W-1:0] top_entry,
    output logic                      new_min,
    output logic signed [ENTRY_W-1:0] push_entry,
    output pop_dec_t                  pop_dec
);

    logic signed [ENTRY_W-1:0] x_ext;
    logic signed [ENTRY_W-1:0] min_ext;
    logic signed [ENTRY_W:0]   restore_full;

    assign x_ext   = ENTRY_W'(push_value);
    assign min_ext = ENTRY_W'(cur_min);

    // push encode: a value below the minimum on a non-empty stack is stored as 2*x - min
    assign new_min    = stack_empty || (push_value < cur_min);
    assign push_entry = (!stack_empty && (push_value < cur_min))
                        ? ((x_ext <<< 1) - min_ext) : x_ext;

    // pop decode: an entry below the minimum marks a minimum change
    assign restore_full = ((ENTRY_W+1)'(min_ext) <<< 1) - (ENTRY_W+1)'(top_entry);

    always_comb
    begin
        pop_dec.take_min     = top_entry < min_ext;
        pop_dec.value        = pop_dec.take_min ? cur_min : top_entry[VALUE_W-1:0];
        pop_dec.restored_min = pop_dec.take_min ? restore_full[VALUE_W-1:0] : cur_min;
    end

endmodule

>>> design/min_tracking_stack.sv
`timescale 1ns / 1ps

// Stack of signed 32-bit values that also reports its running minimum, kept in
// one entry RAM of 34-bit words (values below the minimum are stored encoded).
// Push and minimum read put their result straight into the output register; a pop
// first reads the top entry through the registered RAM read port, and no new
// item is taken until the pop is resolved. Each item gives one result transfer held
// in an output register; while that result is stalled, req_stall stays high.
// The entry RAM is not cleared at reset: entries are only read below the fill count.
module min_tracking_stack
    import mts_pkg::*;
#(
    parameter int STACK_DEPTH = 256
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int ADDR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

    logic [CNT_W-1:0]          count_reg, count_next;
    logic signed [VALUE_W-1:0] min_reg, min_next;
    logic                      pend_reg, pend_next;
    logic                      rsp_valid_reg, rsp_valid_next;
    rsp_t                      rsp_reg, rsp_next;

    logic                      accept;
    logic                      stack_empty;
    logic                      stack_full;
    logic [CNT_W-1:0]          count_dec;
    logic                      wr_en;
    logic                      rd_en;
    logic signed [ENTRY_W-1:0] rd_data;
    logic                      new_min;
    logic signed [ENTRY_W-1:0] push_entry;
    pop_dec_t                  pop_dec;

    // input side waits on a pending pop or a stalled result
    assign req_stall = pend_reg || (rsp_valid_reg && rsp_stall);
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    assign stack_empty = count_reg == '0;
    assign stack_full  = count_reg == CNT_W'(STACK_DEPTH);
    assign count_dec   = count_reg - CNT_W'(1);

    mts_min_unit u_min (
        .push_value  (req.push_value),
        .cur_min     (min_reg),
        .stack_empty (stack_empty),
        .top_entry   (rd_data),
        .new_min     (new_min),
        .push_entry  (push_entry),
        .pop_dec     (pop_dec)
    );

    mts_entry_ram #(
        .DEPTH  (STACK_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (push_entry),
        .rd_en   (rd_en),
        .rd_addr (count_dec[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    // operation decode and result build
    always_comb
    begin
        count_next     = count_reg;
        min_next       = min_reg;
        pend_next      = 1'b0;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        wr_en          = 1'b0;
        rd_en          = 1'b0;

        if (pend_reg)
        begin
            // pop resolves with the top entry from the ram
            min_next              = pop_dec.restored_min;
            rsp_next.result_value = pop_dec.value;
            rsp_next.status       = STATUS_OK;
            rsp_valid_next        = 1'b1;
        end
        else if (accept)
        begin
            rsp_valid_next        = 1'b1;
            rsp_next.result_value = '0;
            rsp_next.status       = STATUS_OK;
            unique case (req.func)
                FUNC_PUSH:
                begin
                    if (stack_full)
                    begin
                        rsp_next.status = STATUS_FULL;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                        if (new_min)
                        begin
                            min_next = req.push_value;
                        end
                    end
                end
                FUNC_POP:
                begin
                    if (stack_empty)
                    begin
                        rsp_next.result_value = '1;
                        rsp_next.status       = STATUS_EMPTY;
                    end
                    else
                    begin
                        rd_en          = 1'b1;
                        count_next     = count_dec;
                        pend_next      = 1'b1;
                        rsp_valid_next = 1'b0;
                    end
                end
                FUNC_MIN_RD:
                begin
                    if (stack_empty)
                    begin
                        rsp_next.result_value = '1;
                        rsp_next.status       = STATUS_EMPTY;
                    end
                    else
                    begin
                        rsp_next.result_value = min_reg;
                    end
                end
                default:
                begin
                    rsp_next.result_value = '0;
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            min_reg       <= '0;
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            min_reg       <= min_next;
            pend_reg      <= pend_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

endmodule

>>> dv/min_tracking_stack_checker.sv
`timescale 1ns / 1ps

module min_tracking_stack_checker
    import mts_pkg::*;
#(
    parameter int STACK_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_stall,
    input  req_t        req,
    input  logic        rsp_valid,
    input  logic        rsp_stall,
    input  rsp_t        rsp,
    output int unsigned fail_count,
    output int unsigned pending
);

    // shadow copy of the stack, with entries encoded as in the block
    logic signed [ENTRY_W-1:0] entries [STACK_DEPTH];
    int unsigned               fill;
    logic signed [VALUE_W-1:0] run_min;

    // results still owed by the block, oldest first
    rsp_t pending_results [$];
    rsp_t oldest;

    initial
    begin
        fill       = 0;
        run_min    = '0;
        fail_count = 0;
        pending    = 0;
    end

    // apply one operation to the shadow stack and return its result
    function automatic rsp_t predict_result(input req_t op);
        logic signed [ENTRY_W-1:0] x_ext;
        logic signed [ENTRY_W-1:0] min_ext;
        logic signed [ENTRY_W-1:0] top;
        rsp_t                      r;
        x_ext          = ENTRY_W'(op.push_value);
        min_ext        = ENTRY_W'(run_min);
        r.result_value = '0;
        r.status       = STATUS_OK;
        case (op.func)
            FUNC_PUSH:
            begin
                if (fill >= STACK_DEPTH)
                begin
                    r.status = STATUS_FULL;
                end
                else
                begin
                    if (fill == 0)
                    begin
                        entries[0] = x_ext;
                        run_min    = op.push_value;
                    end
                    else if (x_ext < min_ext)
                    begin
                        // new minimum: store 2x - old minimum
                        entries[fill] = (x_ext <<< 1) - min_ext;
                        run_min       = op.push_value;
                    end
                    else
                    begin
                        entries[fill] = x_ext;
                    end
                    fill++;
                end
            end
            FUNC_POP:
            begin
                if (fill == 0)
                begin
                    r.result_value = -1;
                    r.status       = STATUS_EMPTY;
                end
                else
                begin
                    fill--;
                    top = entries[fill];
                    if (top < min_ext)
                    begin
                        // encoded top: give back the minimum, recover the old one
                        r.result_value = run_min;
                        run_min        = VALUE_W'((min_ext <<< 1) - top);
                    end
                    else
                    begin
                        r.result_value = top[VALUE_W-1:0];
                    end
                end
            end
            FUNC_MIN_RD:
            begin
                if (fill == 0)
                begin
                    r.result_value = -1;
                    r.status       = STATUS_EMPTY;
                end
                else
                begin
                    r.result_value = run_min;
                end
            end
            default:
            begin
                // unused code leaves everything as is
            end
        endcase
        return r;
    endfunction

    // predict on each request transfer, compare on each result transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                pending_results.push_back(predict_result(req));
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result value %0d status %0d",
                                 $realtime, rsp.result_value, rsp.status);
                end
                else
                begin
                    oldest = pending_results.pop_front();
                    if (rsp.result_value !== oldest.result_value ||
                        rsp.status !== oldest.status)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: mismatch: value %0d status %0d, want %0d %0d",
                                     $realtime, rsp.result_value, rsp.status,
                                     oldest.result_value, oldest.status);
                    end
                end
            end
            pending = pending_results.size();
        end
    end

endmodule

>>> dv/min_tracking_stack_test.sv
`timescale 1ns / 1ps

module min_tracking_stack_test;

    import mts_pkg::*;

    localparam int         DEPTH          = 256;
    localparam int         WATCHDOG_LIMIT = 5000;
    localparam logic [1:0] FUNC_UNUSED    = 2'd3;
    localparam logic signed [VALUE_W-1:0] INT_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] INT_MAX = 32'sh7fff_ffff;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    req_t        req;
    logic        rsp_valid;
    logic        rsp_stall;
    rsp_t        rsp;
    int unsigned fail_count;
    int unsigned pending;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          quiet_cycles;

    min_tracking_stack #(
        .STACK_DEPTH (DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    min_tracking_stack_checker #(
        .STACK_DEPTH (DEPTH)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // receiver back-pressure
    always @(negedge clk)
    begin
        rsp_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);
    end

    // end the run if no transfer happens for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // mix of extremes, values near zero and full-range values
    function automatic logic signed [VALUE_W-1:0] rand_value();
        case ($urandom_range(9))
            0:       return INT_MIN;
            1:       return INT_MAX;
            2:       return $urandom_range(1) ? -1 : 0;
            3, 4, 5: return $signed(32'($urandom_range(200))) - 100;
            default: return $signed($urandom);
        endcase
    endfunction

    function automatic logic [1:0] pick_func(input int push_pct, input int pop_pct);
        int r;
        r = $urandom_range(99);
        if (r < push_pct)
            return FUNC_PUSH;
        else if (r < push_pct + pop_pct)
            return FUNC_POP;
        else if (r < 98)
            return FUNC_MIN_RD;
        else
            return FUNC_UNUSED;
    endfunction

    // one request transfer, called and returning at a falling edge
    task automatic send_item(input logic [1:0] func, input logic signed [VALUE_W-1:0] value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= '{func: func, push_value: value};
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic random_burst(input int count, input int push_pct, input int pop_pct);
        repeat (count)
            send_item(pick_func(push_pct, pop_pct), rand_value());
    endtask

    initial
    begin
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req           = '0;
        rsp_stall     = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        quiet_cycles  = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 24;
        recv_idle_pct = 51;

        // empty stack cases
        send_item(FUNC_POP, 32'sd5);
        send_item(FUNC_MIN_RD, 32'sd0);
        send_item(FUNC_UNUSED, 32'sd7);
        // first push, then a push below the minimum with the widest encoding
        send_item(FUNC_PUSH, INT_MAX);
        send_item(FUNC_MIN_RD, 32'sd0);
        send_item(FUNC_PUSH, INT_MIN);
        send_item(FUNC_MIN_RD, 32'sd0);
        // equal to the minimum is stored plain
        send_item(FUNC_PUSH, INT_MIN);
        send_item(FUNC_PUSH, 32'sd0);
        send_item(FUNC_PUSH, -32'sd1);
        send_item(FUNC_UNUSED, -32'sd1);
        send_item(FUNC_POP, INT_MAX);
        send_item(FUNC_POP, INT_MIN);
        send_item(FUNC_POP, 32'sd0);
        send_item(FUNC_MIN_RD, -32'sd1);
        // encoded top: minimum returns to the first value
        send_item(FUNC_POP, 32'sd0);
        send_item(FUNC_MIN_RD, 32'sd0);
        send_item(FUNC_PUSH, -32'sd5);
        send_item(FUNC_PUSH, -32'sd7);
        send_item(FUNC_POP, 32'sd0);
        send_item(FUNC_POP, 32'sd0);
        send_item(FUNC_POP, 32'sd0);
        send_item(FUNC_POP, 32'sd0);
        send_item(FUNC_MIN_RD, 32'sd0);

        // climb until full, with dropped pushes at the top
        random_burst(410, 80, 10);

        send_idle_pct = 51;
        recv_idle_pct = 24;
        // drain down past empty
        random_burst(430, 10, 80);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        // balanced walk near the bottom
        random_burst(440, 46, 44);

        req_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (16) @(posedge clk);

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
